// ----- rtl/pid_controller_step_macros.svh -----
// Assertion macros for the PID controller step block.
// Used by the port-level checker; depends on nothing else.
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/pcs_pkg.sv -----
// Shared types, constants and clamp function for the PID controller step.
// No dependencies; imported by pid_controller_step and its testbench.
`default_nettype none

package pcs_pkg;

  localparam int DataW  = 16;           // measurement, drive, limits, setpoint
  localparam int GainW  = 16;           // unsigned Q8.8 gains
  localparam int DiffW  = DataW + 1;    // error and measurement change
  localparam int ProdW  = GainW + 1 + DiffW; // gain times difference
  localparam int IntegW = 24;           // integral, 8 fraction bits
  localparam int FracW  = 8;
  localparam int WideW  = ProdW + 2;    // sum of three terms
  localparam int IdxW   = 3;

  typedef logic signed [DataW-1:0]  data_t;
  typedef logic        [GainW-1:0]  gain_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [IntegW-1:0] integ_t;
  typedef logic signed [WideW-1:0]  wide_t;

  // Register indexes of the configuration port
  typedef enum logic [IdxW-1:0] {
    RegPropGain  = 3'd0,
    RegIntegGain = 3'd1,
    RegDerivGain = 3'd2,
    RegSetpoint  = 3'd3,
    RegDriveMin  = 3'd4,
    RegDriveMax  = 3'd5,
    RegAutoMode  = 3'd6,
    RegReverse   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    wide_t value;
    logic  hit;
  } clamp_res_t;

  // Clamp with the upper limit tested first, report whether limited
  function automatic clamp_res_t clamp_hl(wide_t v, wide_t lo, wide_t hi);
    clamp_res_t r;
    if (v > hi) begin
      r.value = hi;
      r.hit   = 1'b1;
    end else if (v < lo) begin
      r.value = lo;
      r.hit   = 1'b1;
    end else begin
      r.value = v;
      r.hit   = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pid_controller_step.sv -----
// PID controller step, derivative on measurement, in fixed point. One measurement
// is taken per transfer and one drive value (with a clamp flag) comes back for
// each. The block sustains one item per clock while the output side does not stall:
// the integral, the previous measurement and the held drive are updated together
// from the input register, and that state loop sets the rate. A result is loaded
// into the output register from the input register and, when the output side does
// not stall, is taken at the next edge. The input register and the output
// register each hold one item, so an item is taken while a finished result still
// waits. Configuration writes are taken in any cycle (cfg_ready stays high) and
// must only be issued while the block is idle.
// Depends on pcs_pkg.
`default_nettype none

module pid_controller_step (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  signed [pcs_pkg::DataW-1:0] measurement,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic signed [pcs_pkg::DataW-1:0] drive,
  output logic                       clamped,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire         [pcs_pkg::IdxW-1:0]  cfg_index,
  input  wire         [pcs_pkg::DataW-1:0] cfg_data
);
  import pcs_pkg::*;

  // Configuration registers
  gain_t prop_gain;
  gain_t integ_gain;
  gain_t deriv_gain;
  data_t setpoint;
  data_t drive_minimum;
  data_t drive_maximum;
  logic  automatic_mode;
  logic  reverse_action;

  // Controller state
  integ_t integral_sum;
  data_t  previous_measurement;
  data_t  held_drive;

  // Pipeline registers
  logic  s1_valid;
  data_t s1_meas;

  logic cfg_write;
  logic advance;
  logic in_xfer;

  data_t      lim_min_next;
  data_t      lim_max_next;
  clamp_res_t held_lim;
  clamp_res_t integ_lim;

  diff_t      err;
  diff_t      dmeas;
  prod_t      p_prop;
  prod_t      p_integ;
  prod_t      p_deriv;
  wide_t      integ_lo;
  wide_t      integ_hi;
  clamp_res_t integ_new;
  wide_t      pid_sum;
  wide_t      pid_floor;
  clamp_res_t drive_new;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Output register frees up when empty or taken this cycle
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Limits as they stand after this write, for clamping the state at once
  always_comb begin
    lim_min_next = drive_minimum;
    lim_max_next = drive_maximum;
    if (cfg_write && cfg_reg_t'(cfg_index) == RegDriveMin) begin
      lim_min_next = data_t'(cfg_data);
    end
    if (cfg_write && cfg_reg_t'(cfg_index) == RegDriveMax) begin
      lim_max_next = data_t'(cfg_data);
    end
    held_lim  = clamp_hl(wide_t'(held_drive), wide_t'(lim_min_next),
                         wide_t'(lim_max_next));
    integ_lim = clamp_hl(wide_t'(integral_sum),
                         wide_t'(lim_min_next) <<< FracW,
                         wide_t'(lim_max_next) <<< FracW);
  end

  // One controller step on the registered measurement
  always_comb begin
    err   = diff_t'(setpoint) - diff_t'(s1_meas);
    dmeas = diff_t'(s1_meas) - diff_t'(previous_measurement);
    if (reverse_action) begin
      err   = -err;
      dmeas = -dmeas;
    end
    p_prop  = $signed({1'b0, prop_gain}) * err;
    p_integ = $signed({1'b0, integ_gain}) * err;
    p_deriv = $signed({1'b0, deriv_gain}) * dmeas;

    integ_lo  = wide_t'(drive_minimum) <<< FracW;
    integ_hi  = wide_t'(drive_maximum) <<< FracW;
    integ_new = clamp_hl(wide_t'(integral_sum) + wide_t'(p_integ), integ_lo, integ_hi);

    // Q.8 sum, floor to integer, then clamp to the drive limits
    pid_sum   = wide_t'(p_prop) + wide_t'(integ_t'(integ_new.value[IntegW-1:0]))
                - wide_t'(p_deriv);
    pid_floor = pid_sum >>> FracW;
    drive_new = clamp_hl(pid_floor, wide_t'(drive_minimum), wide_t'(drive_maximum));
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_meas <= data_t'(measurement);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (automatic_mode) begin
        drive   <= data_t'(drive_new.value[DataW-1:0]);
        clamped <= drive_new.hit;
      end else begin
        drive   <= held_drive;
        clamped <= 1'b0;
      end
    end
  end

  // Configuration registers and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain            <= GainW'(256);
      integ_gain           <= '0;
      deriv_gain           <= '0;
      setpoint             <= '0;
      drive_minimum        <= data_t'(-32768);
      drive_maximum        <= data_t'(32767);
      automatic_mode       <= 1'b1;
      reverse_action       <= 1'b0;
      integral_sum         <= '0;
      previous_measurement <= '0;
      held_drive           <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        RegPropGain:  prop_gain  <= cfg_data;
        RegIntegGain: integ_gain <= cfg_data;
        RegDerivGain: deriv_gain <= cfg_data;
        RegSetpoint:  setpoint   <= data_t'(cfg_data);
        RegDriveMin, RegDriveMax: begin
          drive_minimum <= lim_min_next;
          drive_maximum <= lim_max_next;
          if (automatic_mode) begin
            held_drive   <= data_t'(held_lim.value[DataW-1:0]);
            integral_sum <= integ_t'(integ_lim.value[IntegW-1:0]);
          end
        end
        RegAutoMode:  automatic_mode <= cfg_data[0];
        RegReverse:   reverse_action <= cfg_data[0];
        default: begin
        end
      endcase
    end else if (advance && s1_valid) begin
      previous_measurement <= s1_meas;
      if (automatic_mode) begin
        integral_sum <= integ_t'(integ_new.value[IntegW-1:0]);
        held_drive   <= data_t'(drive_new.value[DataW-1:0]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pcs_checker.sv -----
// Port-level checker for the PID controller step, bound to the top level.
// Depends on pid_controller_step_macros.svh.
`default_nettype none
`include "pid_controller_step_macros.svh"

module pcs_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] drive,
  input wire        clamped,
  input wire        cfg_ready
);

  // Stalled result holds
  `PCS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(drive) && $stable(clamped))
  // Every input transfer produces a result through the input and output registers, or one is still waiting
  `PCS_ASSERT_NOW(a_in_to_out, clk, rst, in_valid && !in_stall, ##2 out_valid)
  // Never stall the input while the output side is empty
  `PCS_ASSERT_NOW(a_no_idle_stall, clk, rst, !out_valid, !in_stall)
  // Configuration port always takes a write
  `PCS_ASSERT_NOW(a_cfg_ready, clk, rst, 1'b1, cfg_ready)

endmodule

bind pid_controller_step pcs_checker u_pcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .clamped   (clamped),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

// ----- tb/pid_controller_step_test.sv -----
// Self-checking testbench for pid_controller_step: a directed table, then random phases
// of register writes and measurement transfers, all checked against an internal predictor.
// Depends on pcs_pkg and the pid_controller_step RTL.
`default_nettype none

module pid_controller_step_test;
  import pcs_pkg::*;

  localparam int RandomItems = 550;
  localparam int CycleLimit  = 400000;

  typedef struct {
    gain_t prop_gain;
    gain_t integ_gain;
    gain_t deriv_gain;
    data_t target;
    data_t drive_lo;
    data_t drive_hi;
    logic  auto_on;
    logic  reversed;
  } pid_regs_t;

  typedef struct {
    data_t drive;
    logic  clamped;
  } drive_exp_t;

  // Typed-in expectation for a directed transfer, if any
  typedef struct {
    bit    fixed;
    data_t drive;
    logic  clamped;
  } sample_note_t;

  typedef struct {
    bit          is_write;
    cfg_reg_t    idx;
    logic [15:0] wdata;
    data_t       meas;
    bit          fixed;
    data_t       drive;
    logic        clamped;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  data_t               measurement = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  data_t               drive;
  logic                clamped;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IdxW-1:0]     cfg_index = '0;
  logic [DataW-1:0]    cfg_data = '0;

  // Predictor state
  pid_regs_t           pid_regs;
  longint              integ_acc;
  longint              prev_meas;
  longint              last_drive;

  drive_exp_t          expected_drives[$];
  sample_note_t        sample_notes[$];
  int                  items_sent = 0;
  int                  items_accepted = 0;
  int                  errors = 0;
  int                  cycle_count = 0;
  int                  stall_left = 0;
  bit                  idle_quiet = 1'b0;
  bit                  stall_quiet = 1'b0;

  pid_controller_step dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .measurement(measurement),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .drive      (drive),
    .clamped    (clamped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Clamp testing the upper limit first
  function automatic longint limit_to(longint v, longint lo, longint hi, output logic hit);
    hit = 1'b1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    hit = 1'b0;
    return v;
  endfunction

  function automatic void reset_model();
    pid_regs.prop_gain  = 16'd256;
    pid_regs.integ_gain = '0;
    pid_regs.deriv_gain = '0;
    pid_regs.target     = '0;
    pid_regs.drive_lo   = data_t'(-32768);
    pid_regs.drive_hi   = data_t'(32767);
    pid_regs.auto_on    = 1'b1;
    pid_regs.reversed   = 1'b0;
    integ_acc  = 0;
    prev_meas  = 0;
    last_drive = 0;
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [15:0] v);
    logic h;
    case (idx)
      RegPropGain:  pid_regs.prop_gain  = v;
      RegIntegGain: pid_regs.integ_gain = v;
      RegDerivGain: pid_regs.deriv_gain = v;
      RegSetpoint:  pid_regs.target     = data_t'(v);
      RegDriveMin, RegDriveMax: begin
        if (idx == RegDriveMin) pid_regs.drive_lo = data_t'(v);
        else pid_regs.drive_hi = data_t'(v);
        // pull held drive and integral into the new limits at once
        if (pid_regs.auto_on) begin
          last_drive = limit_to(last_drive, pid_regs.drive_lo, pid_regs.drive_hi, h);
          integ_acc  = limit_to(integ_acc, longint'(pid_regs.drive_lo) * 256,
                                longint'(pid_regs.drive_hi) * 256, h);
        end
      end
      RegAutoMode:  pid_regs.auto_on  = v[0];
      RegReverse:   pid_regs.reversed = v[0];
      default: ;
    endcase
  endfunction

  // One control step: returns the drive and clamp flag, advances the state
  function automatic void predict_drive(data_t m, output data_t d, output logic hit);
    longint kp, ki, kd, err, dm, lo, hi, acc;
    logic   h;
    if (!pid_regs.auto_on) begin
      prev_meas = m;
      d   = data_t'(last_drive);
      hit = 1'b0;
      return;
    end
    kp = longint'(pid_regs.prop_gain);
    ki = longint'(pid_regs.integ_gain);
    kd = longint'(pid_regs.deriv_gain);
    if (pid_regs.reversed) begin
      kp = -kp;
      ki = -ki;
      kd = -kd;
    end
    lo  = longint'(pid_regs.drive_lo);
    hi  = longint'(pid_regs.drive_hi);
    err = longint'(pid_regs.target) - longint'(m);
    dm  = longint'(m) - prev_meas;
    integ_acc = limit_to(integ_acc + ki * err, lo * 256, hi * 256, h);
    // exact Q.8 sum, floored by the arithmetic shift
    acc = kp * err + integ_acc - kd * dm;
    last_drive = limit_to(acc >>> 8, lo, hi, hit);
    prev_meas  = m;
    d = data_t'(last_drive);
  endfunction

  // Check results, apply register writes, predict accepted transfers
  always @(posedge clk) begin
    drive_exp_t   exp_item;
    sample_note_t note;
    data_t        pd;
    logic         pc;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, drive=%0d", drive));
        end else begin
          exp_item = expected_drives.pop_front();
          if (drive !== exp_item.drive)
            report_mismatch($sformatf("drive %0d, expected %0d", drive, exp_item.drive));
          if (clamped !== exp_item.clamped)
            report_mismatch($sformatf("clamped %b, expected %b", clamped, exp_item.clamped));
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && !in_stall) begin
        note = sample_notes.pop_front();
        predict_drive(measurement, pd, pc);
        if (note.fixed) begin
          pd = note.drive;
          pc = note.clamped;
        end
        expected_drives.push_back('{pd, pc});
        items_accepted++;
      end
    end
  end

  // Output stall: runs of random length, mostly short, none while quiet
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      r = $urandom_range(0, 99);
      if (!stall_quiet) begin
        if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 24) stall_left = $urandom_range(4, 24);
      end
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic data_t pick_measurement();
    int r;
    int off;
    r   = $urandom_range(0, 9);
    off = int'($urandom_range(0, 400)) - 200;
    if (r == 0) return ($urandom_range(0, 1) != 0) ? data_t'(32767) : data_t'(-32768);
    if (r < 4) return data_t'($urandom);
    return data_t'(int'(pid_regs.target) + off);
  endfunction

  function automatic logic [15:0] pick_reg_value(cfg_reg_t idx);
    int r;
    r = $urandom_range(0, 9);
    case (idx)
      RegPropGain, RegIntegGain, RegDerivGain: begin
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        if (r < 4) return 16'($urandom);
        return 16'($urandom_range(0, 768));
      end
      RegSetpoint: begin
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        if (r < 5) return 16'($urandom);
        return 16'(int'($urandom_range(0, 4000)) - 2000);
      end
      RegDriveMin: begin
        if (r < 2) return 16'h8000;
        if (r == 2) return 16'($urandom);
        return 16'(-int'($urandom_range(0, 20000)));
      end
      RegDriveMax: begin
        if (r < 2) return 16'h7FFF;
        if (r == 2) return 16'($urandom);
        return 16'($urandom_range(0, 20000));
      end
      // upper bits are noise, only bit zero counts
      RegAutoMode: return {15'($urandom), 1'(r < 8)};
      default:     return {15'($urandom), 1'(r < 5)};
    endcase
  endfunction

  // Drop valid and hold until every transfer has produced its result
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (items_accepted != items_sent || expected_drives.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(data_t m, bit fixed, data_t d, logic c);
    int gap;
    gap = pick_gap(idle_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_notes.push_back('{fixed, d, c});
    in_valid    <= 1'b1;
    measurement <= m;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic stim_row_t reg_row(cfg_reg_t idx, int v);
    return '{1'b1, idx, 16'(v), '0, 1'b0, '0, 1'b0};
  endfunction

  function automatic stim_row_t free_row(int m);
    return '{1'b0, RegPropGain, '0, data_t'(m), 1'b0, '0, 1'b0};
  endfunction

  function automatic stim_row_t fixed_row(int m, int d, logic c);
    return '{1'b0, RegPropGain, '0, data_t'(m), 1'b1, data_t'(d), c};
  endfunction

  initial begin
    stim_row_t rows[$];
    cfg_reg_t  reg_idx;
    int        random_sent;
    int        n_items;
    int        n_writes;
    random_sent = 0;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    rows = '{
      // after reset: unity proportional gain, full limits
      fixed_row(0, 0, 1'b0),
      fixed_row(100, -100, 1'b0),
      fixed_row(-32768, 32767, 1'b1),
      fixed_row(32767, -32767, 1'b0),
      reg_row(RegPropGain, 16'hFFFF),
      fixed_row(1000, -32768, 1'b1),
      fixed_row(-1000, 32767, 1'b1),
      reg_row(RegPropGain, 0),
      fixed_row(5, 0, 1'b0),
      // integral path, then saturation of the integral
      reg_row(RegIntegGain, 256),
      free_row(-10),
      free_row(-10),
      reg_row(RegIntegGain, 16'hFFFF),
      free_row(-32768),
      free_row(32767),
      // derivative on full-scale measurement swings
      reg_row(RegIntegGain, 0),
      reg_row(RegDerivGain, 16'hFFFF),
      free_row(-32768),
      free_row(32767),
      // reverse action with all gains active
      reg_row(RegDerivGain, 256),
      reg_row(RegPropGain, 16'h0180),
      reg_row(RegIntegGain, 64),
      reg_row(RegReverse, 1),
      free_row(300),
      free_row(-300),
      // largest errors of both signs
      reg_row(RegSetpoint, 32767),
      free_row(-32768),
      reg_row(RegSetpoint, -32768),
      free_row(32767),
      // narrow limits written in auto mode clamp the state at once
      reg_row(RegReverse, 0),
      reg_row(RegDriveMin, -100),
      reg_row(RegDriveMax, 100),
      free_row(0),
      // minimum above maximum
      reg_row(RegDriveMin, 50),
      reg_row(RegDriveMax, -50),
      free_row(-32768),
      free_row(32767),
      // manual hold; limits written in manual leave the state alone
      reg_row(RegAutoMode, 0),
      free_row(1234),
      reg_row(RegDriveMin, -32768),
      reg_row(RegDriveMax, 32767),
      free_row(-5),
      reg_row(RegAutoMode, 1),
      reg_row(RegSetpoint, 0),
      reg_row(RegPropGain, 256),
      free_row(7)
    };
    foreach (rows[i]) begin
      if (rows[i].is_write) write_reg(rows[i].idx, rows[i].wdata);
      else send_sample(rows[i].meas, rows[i].fixed, rows[i].drive, rows[i].clamped);
    end

    // Random phases: a few register writes, then a burst of transfers
    while (random_sent < RandomItems) begin
      n_writes = $urandom_range(1, 5);
      repeat (n_writes) begin
        reg_idx = cfg_reg_t'($urandom_range(0, 7));
        write_reg(reg_idx, pick_reg_value(reg_idx));
      end
      idle_quiet  = ($urandom_range(0, 4) == 0);
      stall_quiet = ($urandom_range(0, 4) == 0);
      n_items = $urandom_range(10, 50);
      repeat (n_items) send_sample(pick_measurement(), 1'b0, '0, 1'b0);
      random_sent += n_items;
    end

    // Drain and let any stray result show up
    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_drives.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_drives.size()));
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
